// ===== rtl/core/s256rr_pkg.sv =====
// Package for the reduced-round SHA-256 state core: round constants,
// initial hash value and the sigma functions of the round and the schedule.
// No dependencies.
`default_nettype none

package s256rr_pkg;

   localparam int unsigned MAX_ROUNDS_DEFAULT = 64;
   localparam logic [6:0] DEFAULT_ROUNDS = 7'd57;

   typedef logic [31:0] word_type;

   localparam word_type INIT_VALUE [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type big_sig0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sig1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sig0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sig1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   function automatic word_type round_k(input logic [5:0] idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha256_reduced_round_state_core.sv =====
// Reduced-round SHA-256 compression core: loads 16 message words, runs the
// schedule and rounds from the standard IV, emits a..h without feed-forward.
// Depends on s256rr_pkg.
`default_nettype none

// Channel   Direction  Ports                                   Handshake
// request   in         start, busy, req_message_word           start & !busy
// response  out        rsp_valid, rsp_state_word,              rsp_valid, one-cycle
//                      rsp_word_index, rsp_last_word           strobe, no back-pressure
// csr       in         csr_write_en, csr_write_data            csr_write_en
//
// Words 1..15 of a block are shifted in, one per start, while busy stays low.
// The sixteenth word starts the round engine: the rounds (1..MAX_ROUNDS, set by
// the round count latched at that word) run in turn, then eight responses follow.
// Busy stays high through the round and emit states.
// The round datapath (schedule adder, T1/T2 adders) is shared by all rounds.
// Synchronous reset clears control state and sets the round count to 57.
// The receiver cannot stall; each response appears for exactly one cycle.

module sha256_reduced_round_state_core
   import s256rr_pkg::*;
#(
   parameter int unsigned MAX_ROUNDS = MAX_ROUNDS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_message_word,
   output logic             rsp_valid,
   output logic [31:0]      rsp_state_word,
   output logic [2:0]       rsp_word_index,
   output logic             rsp_last_word,
   input  wire logic        csr_write_en,
   input  wire logic [6:0]  csr_write_data
);

   localparam int unsigned RW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;
   localparam logic [6:0] MAX_ROUNDS_7 = 7'(MAX_ROUNDS);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_ROUND,
      ST_EMIT
   } state_type;

   state_type      state_ff;
   logic [6:0]     round_count_ff;
   logic [3:0]     load_count_ff;
   logic [RW-1:0]  round_ff;
   logic [RW-1:0]  last_round_ff;
   logic [2:0]     emit_ff;
   word_type       window_ff [16];
   word_type       var_ff [8];

   // Round count as used: zero runs one round, large values clamp to MAX_ROUNDS.
   logic [6:0]     last_round_in;
   word_type       sched_in;
   word_type       t1;
   word_type       t2;
   word_type       ch;
   word_type       maj;

   always_comb begin
      if (round_count_ff == 7'd0) begin
         last_round_in = 7'd0;
      end else if (round_count_ff > MAX_ROUNDS_7) begin
         last_round_in = MAX_ROUNDS_7 - 7'd1;
      end else begin
         last_round_in = round_count_ff - 7'd1;
      end
   end

   // Window holds W[t..t+15]; window_ff[0] is the word of the current round.
   assign sched_in = small_sig1(window_ff[14]) + window_ff[9]
                   + small_sig0(window_ff[1]) + window_ff[0];

   assign ch  = (var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]);
   assign maj = (var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2])
              ^ (var_ff[1] & var_ff[2]);
   assign t1  = var_ff[7] + big_sig1(var_ff[4]) + ch
              + round_k(6'(round_ff)) + window_ff[0];
   assign t2  = big_sig0(var_ff[0]) + maj;

   assign busy = (state_ff != ST_LOAD);

   // Control and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         round_count_ff <= DEFAULT_ROUNDS;
         load_count_ff  <= 4'd0;
         round_ff       <= '0;
         last_round_ff  <= '0;
         emit_ff        <= 3'd0;
         rsp_valid      <= 1'b0;
         rsp_state_word <= '0;
         rsp_word_index <= 3'd0;
         rsp_last_word  <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_write_en) begin
            round_count_ff <= csr_write_data;
         end
         case (state_ff)
            ST_LOAD: begin
               if (start) begin
                  load_count_ff <= load_count_ff + 4'd1;
                  if (load_count_ff == 4'd15) begin
                     // latch the round count in force at the last word
                     round_ff      <= '0;
                     last_round_ff <= RW'(last_round_in);
                     state_ff      <= ST_ROUND;
                  end
               end
            end
            ST_ROUND: begin
               round_ff <= round_ff + RW'(1);
               if (round_ff == last_round_ff) begin
                  emit_ff  <= 3'd0;
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               // present a first; the datapath advances the variables
               rsp_valid      <= 1'b1;
               rsp_state_word <= var_ff[0];
               rsp_word_index <= emit_ff;
               rsp_last_word  <= (emit_ff == 3'd7);
               emit_ff        <= emit_ff + 3'd1;
               if (emit_ff == 3'd7) begin
                  state_ff <= ST_LOAD;
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   // Datapath: schedule window and working variables
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_LOAD: begin
            if (start) begin
               // shift the new word in at the top of the window
               for (int i = 0; i < 15; i++) begin
                  window_ff[i] <= window_ff[i+1];
               end
               window_ff[15] <= req_message_word;
               if (load_count_ff == 4'd15) begin
                  for (int i = 0; i < 8; i++) begin
                     var_ff[i] <= INIT_VALUE[i];
                  end
               end
            end
         end
         ST_ROUND: begin
            for (int i = 0; i < 15; i++) begin
               window_ff[i] <= window_ff[i+1];
            end
            window_ff[15] <= sched_in;
            var_ff[7] <= var_ff[6];
            var_ff[6] <= var_ff[5];
            var_ff[5] <= var_ff[4];
            var_ff[4] <= var_ff[3] + t1;
            var_ff[3] <= var_ff[2];
            var_ff[2] <= var_ff[1];
            var_ff[1] <= var_ff[0];
            var_ff[0] <= t1 + t2;
         end
         ST_EMIT: begin
            // advance the variables down one place
            for (int i = 0; i < 7; i++) begin
               var_ff[i] <= var_ff[i+1];
            end
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire
